FILE: rtl/pbvc_pkg.sv
package pbvc_pkg;

    localparam int MAX_BOXES = 64;
    localparam int ADDR_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W     = $clog2(MAX_BOXES + 1);

    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;

    localparam int IN_DATA_W  = 288;
    localparam int OUT_DATA_W = 192;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 2'd2;

    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_STATIC  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_DYNAMIC = 2'd2;
    localparam logic [STATUS_W-1:0] STS_FULL    = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [SIZE_W-1:0]  size_t;

    // one stored obstacle box, laid out as on the request bus
    typedef struct packed {
        size_t  w;
        size_t  l;
        size_t  h;
        coord_t vz;
        coord_t vy;
        coord_t vx;
        coord_t cz;
        coord_t cy;
        coord_t cx;
    } box_t;

    localparam int BOX_W = $bits(box_t);

endpackage

FILE: rtl/pbvc_ram.sv
module pbvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/point_box_velocity_classifier_unit.sv
// Obstacle box table with point classification. A request carries a command in
// s_tuser: clear empties the table, load appends one box (status full once the
// table holds MAX_BOXES boxes), classify tests a point against the boxes in load
// order and returns dynamic with the velocity of the first box that contains it
// (inclusive, exact |2*(p-c)| <= size on every axis), else static. Every request
// gives exactly one result. Clear, load and classify on an empty table go straight
// to the finish state; classify otherwise reads the boxes held in load order and
// stops early when a box contains the point. The single box memory read port
// delivers one box per cycle to the shared containment test; the read data is
// registered, and the finish state loads the result into the output register.
// The block takes no request while one is in work; a finished result waits in
// the output register while the next request is accepted.
module point_box_velocity_classifier_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, size_height, size_length,
    // size_width, zero fill
    input  logic [pbvc_pkg::IN_DATA_W-1:0]     s_tdata,
    // command
    input  logic [pbvc_pkg::CMD_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x, out_y, out_z, hit_vel_x, hit_vel_y, hit_vel_z
    output logic [pbvc_pkg::OUT_DATA_W-1:0]    m_tdata,
    // status
    output logic [pbvc_pkg::STATUS_W-1:0]      m_tuser
);

    import pbvc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             hit_reg, hit_next;
    logic             full_reg, full_next;
    logic [CMD_W-1:0] cmd_reg;
    coord_t           px_reg, py_reg, pz_reg;
    coord_t           vx_reg, vy_reg, vz_reg;

    logic                          m_tvalid_reg;
    logic [STATUS_W-1:0]           status_reg;
    logic [OUT_DATA_W-1:0]         odata_reg;

    box_t        req_box;
    box_t        rd_box;
    logic        accept;
    logic        table_full;
    logic        ram_we;
    logic        issuing;
    logic        box_hit;
    logic        out_free;

    assign req_box    = box_t'(s_tdata[BOX_W-1:0]);
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign table_full = (count_reg == CNT_W'(MAX_BOXES));
    assign ram_we     = accept && (s_tuser == CMD_LOAD) && !table_full;
    assign issuing    = (state_reg == S_SCAN) && (idx_reg != count_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    pbvc_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_box_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (req_box),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rd_box)
    );

    // inclusive -size <= 2*(p-c) <= size, no negation of the difference
    function automatic logic axis_inside(coord_t p, coord_t c, size_t size);
        logic signed [COORD_W:0]   d;
        logic signed [COORD_W+2:0] d2;
        logic signed [COORD_W+2:0] sz;
        d  = {p[COORD_W-1], p} - {c[COORD_W-1], c};
        d2 = {d[COORD_W], d, 1'b0};
        sz = {{(COORD_W+3-SIZE_W){1'b0}}, size};
        return (d2 <= sz) && (d2 >= -sz);
    endfunction

    assign box_hit = axis_inside(px_reg, rd_box.cx, rd_box.l)
                  && axis_inside(py_reg, rd_box.cy, rd_box.w)
                  && axis_inside(pz_reg, rd_box.cz, rd_box.h);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        chk_vld_next = 1'b0;
        hit_next     = hit_reg;
        full_next    = full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    hit_next  = 1'b0;
                    full_next = 1'b0;
                    idx_next  = '0;
                    state_next = S_FINISH;
                    unique case (s_tuser)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (table_full)
                            begin
                                full_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_CLASSIFY:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                chk_vld_next = issuing;
                if (issuing)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                // first containing box wins, the rest of the read-ahead is dropped
                if (chk_vld_reg && box_hit)
                begin
                    hit_next     = 1'b1;
                    chk_vld_next = 1'b0;
                    state_next   = S_FINISH;
                end
                else if (!issuing)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            full_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            chk_vld_reg <= chk_vld_next;
            hit_reg     <= hit_next;
            full_reg    <= full_next;
            if ((state_reg == S_FINISH) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            px_reg  <= req_box.cx;
            py_reg  <= req_box.cy;
            pz_reg  <= req_box.cz;
        end
        if ((state_reg == S_SCAN) && chk_vld_reg && box_hit)
        begin
            vx_reg <= rd_box.vx;
            vy_reg <= rd_box.vy;
            vz_reg <= rd_box.vz;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            if (cmd_reg == CMD_CLASSIFY)
            begin
                status_reg <= hit_reg ? STS_DYNAMIC : STS_STATIC;
                if (hit_reg)
                begin
                    odata_reg <= {vz_reg, vy_reg, vx_reg, pz_reg, py_reg, px_reg};
                end
                else
                begin
                    odata_reg <= {{(3*COORD_W){1'b0}}, pz_reg, py_reg, px_reg};
                end
            end
            else
            begin
                status_reg <= full_reg ? STS_FULL : STS_DONE;
                odata_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("box count beyond table size");

    a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= count_reg) && (count_reg != '0))
        else $error("scan index past box count");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == CMD_LOAD) && table_full) |=> table_full && full_reg)
        else $error("load into full table changed the count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tuser) && $stable(m_tdata))
        else $error("pending result overwritten");
`endif

endmodule

FILE: bench/tb_point_box_velocity_classifier_unit.sv
module tb_point_box_velocity_classifier_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pbvc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam coord_t C_MAX = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam size_t  S_MAX = 31'h7FFF_FFFF;
    localparam int STALL_LIMIT = 5000;
    localparam int TARGET_ITEMS = 530;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        coord_t ox;
        coord_t oy;
        coord_t oz;
        coord_t vx;
        coord_t vy;
        coord_t vz;
    } result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        box_t             req;
        bit               typed;
        result_t          res;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    box_t    held_boxes[MAX_BOXES];
    int      held_count = 0;
    result_t pending_results[$];
    dir_row_t dir_rows[$];
    bit      quiet = 1'b0;
    int      mismatches = 0;
    int      sent_items = 0;
    int      cmd_tally[4] = '{default: 0};
    int      status_tally[4] = '{default: 0};
    int      stall_cycles = 0;

    point_box_velocity_classifier_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // exact inclusive test |2*(p-c)| <= size at 64 bits
    function automatic bit axis_hit(coord_t p, coord_t c, size_t sz);
        longint d;
        d = 2 * (longint'(p) - longint'(c));
        if (d < 0)
            d = -d;
        return d <= longint'(sz);
    endfunction

    function automatic result_t box_table_step(logic [CMD_W-1:0] cmd, box_t req);
        result_t r;
        bit hit;
        r = '0;
        r.status = STS_DONE;
        hit = 1'b0;
        case (cmd)
            CMD_CLEAR:
                held_count = 0;
            CMD_LOAD:
                if (held_count >= MAX_BOXES)
                    r.status = STS_FULL;
                else
                begin
                    held_boxes[held_count] = req;
                    held_count++;
                end
            CMD_CLASSIFY:
            begin
                r.status = STS_STATIC;
                r.ox = req.cx;
                r.oy = req.cy;
                r.oz = req.cz;
                for (int i = 0; i < held_count && !hit; i++)
                begin
                    if (axis_hit(req.cx, held_boxes[i].cx, held_boxes[i].l) &&
                        axis_hit(req.cy, held_boxes[i].cy, held_boxes[i].w) &&
                        axis_hit(req.cz, held_boxes[i].cz, held_boxes[i].h))
                    begin
                        hit = 1'b1;
                        r.status = STS_DYNAMIC;
                        r.vx = held_boxes[i].vx;
                        r.vy = held_boxes[i].vy;
                        r.vz = held_boxes[i].vz;
                    end
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic box_t mk_box(coord_t cx, coord_t cy, coord_t cz, coord_t vx,
                                    coord_t vy, coord_t vz, size_t h, size_t l, size_t w);
        box_t b;
        b.cx = cx;
        b.cy = cy;
        b.cz = cz;
        b.vx = vx;
        b.vy = vy;
        b.vz = vz;
        b.h  = h;
        b.l  = l;
        b.w  = w;
        return b;
    endfunction

    function automatic result_t mk_res(logic [STATUS_W-1:0] st, coord_t ox, coord_t oy,
                                       coord_t oz);
        result_t r;
        r = '0;
        r.status = st;
        r.ox = ox;
        r.oy = oy;
        r.oz = oz;
        return r;
    endfunction

    function automatic void add_row(dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
            2: return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
            default:
                case ($urandom_range(0, 3))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
        endcase
    endfunction

    function automatic size_t rand_size();
        case ($urandom_range(0, 3))
            0: return size_t'($urandom);
            1: return size_t'($urandom_range(0, 4096));
            2: return size_t'($urandom_range(0, 4194304));
            default: return ($urandom_range(0, 1) != 0) ? S_MAX : size_t'(0);
        endcase
    endfunction

    function automatic box_t rand_box();
        return mk_box(rand_coord(), rand_coord(), rand_coord(), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), rand_size(), rand_size(),
                      rand_size());
    endfunction

    // coordinate inside, on the edge of, or just past a box along one axis
    function automatic coord_t near_axis(coord_t c, size_t sz, bit inside_only);
        longint half;
        longint off;
        half = longint'(sz) >>> 1;
        case (inside_only ? 0 : $urandom_range(0, 2))
            0: off = longint'($urandom_range(0, 32'(2 * half))) - half;
            1: off = half + longint'($urandom_range(0, 1));
            default: off = half + longint'($urandom_range(1, 3));
        endcase
        if (!inside_only && $urandom_range(0, 1) != 0)
            off = -off;
        return coord_t'(longint'(c) + off);
    endfunction

    task automatic send_req(input logic [CMD_W-1:0] cmd, input box_t req, input bit typed,
                            input result_t typed_res);
        result_t r;
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_DATA_W - BOX_W){1'b0}}, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = box_table_step(cmd, req);
        pending_results.insert(pending_results.size(), typed ? typed_res : r);
        cmd_tally[cmd]++;
        if (cmd != CMD_UNUSED)
            sent_items++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < 40)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= 15);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (m_tvalid && m_tready)
        begin
            status_tally[m_tuser]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, status %0d", $time, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("out_x", want.ox, m_tdata[31:0]);
                check_field("out_y", want.oy, m_tdata[63:32]);
                check_field("out_z", want.oz, m_tdata[95:64]);
                check_field("hit_vel_x", want.vx, m_tdata[127:96]);
                check_field("hit_vel_y", want.vy, m_tdata[159:128]);
                check_field("hit_vel_z", want.vz, m_tdata[191:160]);
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        box_t    b;
        box_t    pick;
        bit      in_box;
        int      n;
        int      phase;
        dir_row_t row;

        // empty table, extremes, ignored fields set
        add_row('{CMD_CLASSIFY, mk_box(C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0),
                             1'b1, mk_res(STS_STATIC, C_MIN, C_MIN, C_MIN)});
        add_row('{CMD_CLASSIFY, mk_box(C_MAX, C_MAX, C_MAX, -1, -1, -1,
                             S_MAX, S_MAX, S_MAX), 1'b1, mk_res(STS_STATIC, C_MAX, C_MAX, C_MAX)});
        add_row('{CMD_UNUSED, mk_box(-1, -1, -1, -1, -1, -1, S_MAX, S_MAX, S_MAX),
                             1'b1, mk_res(STS_DONE, 0, 0, 0)});
        // widest box at origin
        add_row('{CMD_LOAD, mk_box(0, 0, 0, C_MAX, C_MIN, -1, S_MAX, S_MAX, S_MAX),
                             1'b1, mk_res(STS_DONE, 0, 0, 0)});
        add_row('{CMD_CLASSIFY, mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(32'sh3FFF_FFFF, -32'sh3FFF_FFFF, 32'sh3FFF_FFFF,
                             0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_CLEAR, mk_box(-1, -1, -1, -1, -1, -1, S_MAX, S_MAX, S_MAX),
                             1'b1, mk_res(STS_DONE, 0, 0, 0)});
        add_row('{CMD_CLASSIFY, mk_box(0, 0, 0, 0, 0, 0, 0, 0, 0),
                             1'b1, mk_res(STS_STATIC, 0, 0, 0)});
        // zero size box at the negative corner
        add_row('{CMD_LOAD, mk_box(C_MIN, C_MIN, C_MIN, 1, 2, 3, 0, 0, 0),
                             1'b1, mk_res(STS_DONE, 0, 0, 0)});
        add_row('{CMD_CLASSIFY, mk_box(C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(C_MIN + 1, C_MIN, C_MIN, 0, 0, 0, 0, 0, 0),
                             1'b0, '0});
        // even and odd extents, edges inclusive
        add_row('{CMD_LOAD, mk_box(1000, -1000, 50, 10, 20, 30, 0, 4, 5),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(1002, -998, 50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(1003, -1000, 50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(998, -1003, 50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        // overlapping box loaded later loses to the earlier one
        add_row('{CMD_LOAD, mk_box(1000, -1000, 50, -7, -8, -9, 100, 100, 100),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(1000, -1000, 50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(1040, -1000, 50, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        add_row('{CMD_LOAD, mk_box(C_MAX, C_MAX, C_MAX, 32'sh5555_5555,
                             32'shAAAA_AAAA, 0, 31'h2AAA_AAAA, 31'h5555_5555, 31'h7000_0001),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0),
                             1'b0, '0});
        add_row('{CMD_CLASSIFY, mk_box(C_MIN, C_MAX, C_MAX, 0, 0, 0, 0, 0, 0),
                             1'b0, '0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_req(row.cmd, row.req, row.typed, row.res);
        end

        // fill the table, then one load past full
        while (held_count < MAX_BOXES)
            send_req(CMD_LOAD, rand_box(), 1'b0, '0);
        send_req(CMD_LOAD, rand_box(), 1'b1, mk_res(STS_FULL, 0, 0, 0));
        b = rand_box();
        pick = held_boxes[MAX_BOXES - 1];
        b.cx = near_axis(pick.cx, pick.l, 1'b1);
        b.cy = near_axis(pick.cy, pick.w, 1'b1);
        b.cz = near_axis(pick.cz, pick.h, 1'b1);
        send_req(CMD_CLASSIFY, b, 1'b0, '0);

        phase = 0;
        while (sent_items < TARGET_ITEMS)
        begin
            quiet = (phase >= 4 && phase < 8);
            // let the result side drain completely with the sender held off
            if (phase == 2 || phase % 11 == 10)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 3) != 0)
                send_req(CMD_CLEAR, rand_box(), 1'b0, '0);
            if ($urandom_range(0, 9) == 0)
                n = MAX_BOXES - held_count + $urandom_range(1, 2);
            else
                n = $urandom_range(1, 8);
            repeat (n)
                send_req(CMD_LOAD, rand_box(), 1'b0, '0);
            repeat ($urandom_range(4, 20))
            begin
                b = rand_box();
                if ($urandom_range(0, 19) == 0)
                    send_req(CMD_UNUSED, b, 1'b0, '0);
                else
                begin
                    if (held_count > 0 && $urandom_range(0, 4) != 0)
                    begin
                        pick = held_boxes[$urandom_range(0, held_count - 1)];
                        in_box = $urandom_range(0, 9) < 7;
                        b.cx = near_axis(pick.cx, pick.l, in_box);
                        b.cy = near_axis(pick.cy, pick.w, in_box);
                        b.cz = near_axis(pick.cz, pick.h, in_box);
                    end
                    send_req(CMD_CLASSIFY, b, 1'b0, '0);
                end
            end
            phase++;
        end

        quiet = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("requests sent: %0d clear, %0d load, %0d classify, %0d unused code",
                 cmd_tally[CMD_CLEAR], cmd_tally[CMD_LOAD], cmd_tally[CMD_CLASSIFY],
                 cmd_tally[CMD_UNUSED]);
        $display("results seen: %0d done, %0d static, %0d dynamic, %0d full, %0d mismatches",
                 status_tally[STS_DONE], status_tally[STS_STATIC], status_tally[STS_DYNAMIC],
                 status_tally[STS_FULL], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
